/* sv/brs_pkg.sv */
`timescale 1ns / 1ps

package brs_pkg;

    localparam int PERIOD_W  = 16;
    localparam int RATE_W    = 22;
    localparam int WORD_W    = 25;
    localparam int TIME_W    = 32;
    localparam int CNT_W     = 7;
    localparam int IDX_W     = 4;
    localparam int SAMPLES_W = 16;
    localparam int DELTA_W   = 13;
    localparam int TGT_W     = 29;
    localparam int SEC_W     = 30;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd25;
    localparam logic [PERIOD_W-1:0] PERIOD_MIN   = 16'd10;
    localparam logic [RATE_W-1:0]   RATE_MIN     = 22'd62500;
    localparam logic [RATE_W-1:0]   RATE_MAX     = 22'd4000000;
    localparam logic [SEC_W-1:0]    ONE_SECOND_NS = 30'd1000000000;
    localparam logic [CNT_W-1:0]    MAX_RESULTS  = 7'd64;
    localparam logic [SAMPLES_W-1:0] PULSE_MSB   = 16'h8000;

    localparam int CMDQ_DEPTH_DEF = 2;

    typedef struct packed {
        logic              cell_bit;
        logic [RATE_W-1:0] cell_rate;
        logic              last_cell;
    } t_brs_in;

    typedef struct packed {
        logic [SAMPLES_W-1:0] sample_word;
        logic [WORD_W-1:0]    word_number;
        logic                 last_word;
    } t_brs_out;

    typedef struct packed {
        logic [CNT_W-1:0] k1;
        logic             pulse;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] k2;
        logic             last;
    } t_brs_cmd;

endpackage

/* sv/bitcell_to_sample_grid_resampler_core.sv */
`timescale 1ns / 1ps

// Bit cell to sample grid resampler.
// Input queue side: drive i_item and raise i_push; a beat is taken at a rising
// edge with i_push high and o_full low. Each beat is one bit cell.
// Result queue side: while o_empty is low, o_result holds the oldest 16-sample
// word; it is taken at a rising edge with i_pop high. Words leave in order,
// first sample in the MSB, with word number and a flag on the last word of
// a track.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the sample period (ns)
// at the next edge; write only while no cell is in flight.
// Processing: each cell takes two back-to-back passes through the bit-serial
// 32-step period divider (cell length divide runs alongside the first), and
// o_full stays high until the cell is queued. Words are produced one per
// cycle while the result side is not stalled, up to 64 per cell.
// A stalled result side fills the command queue; the front then holds o_full
// high once its finished cell cannot be queued.
// Reset (synchronous, active low) clears the track time, word buffer and word
// count, empties both sides, and sets the sample period to 25 ns.

module bitcell_to_sample_grid_resampler_core
    import brs_pkg::*;
#(
    parameter int CMDQ_DEPTH = CMDQ_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_brs_in             i_item,
    output logic                o_full,
    output logic                o_empty,
    input  logic                i_pop,
    output t_brs_out            o_result,
    input  logic                i_cfg_wr_en,
    input  logic [PERIOD_W-1:0] i_cfg_wr_data
);

    logic [PERIOD_W-1:0] r_sample_period_ns;

    logic     cmd_push;
    t_brs_cmd cmd_in;
    logic     cmd_full;
    logic     cmd_pop;
    t_brs_cmd cmd_out;
    logic     cmd_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_period_ns <= PERIOD_RESET;
        end else if (i_cfg_wr_en) begin
            r_sample_period_ns <= i_cfg_wr_data;
        end
    end

    brs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_item     (i_item),
        .o_full     (o_full),
        .i_period   (r_sample_period_ns),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in),
        .i_cmd_full (cmd_full)
    );

    brs_cmdq #(
        .DEPTH(CMDQ_DEPTH)
    ) u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    brs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd_out),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_result    (o_result)
    );

endmodule

/* sv/brs_div.sv */
`timescale 1ns / 1ps

module brs_div #(
    parameter int N = 32,
    parameter int M = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [N-1:0] i_dividend,
    input  logic [M-1:0] i_divisor,
    output logic         o_done,
    output logic [N-1:0] o_quotient
);

    localparam int CW = $clog2(N + 1);

    logic [M-1:0]  r_rem;
    logic [N-1:0]  r_quo;
    logic [M-1:0]  r_div;
    logic [CW-1:0] r_cnt;
    logic          r_done;

    logic [M:0]   shifted;
    logic [M+1:0] diff;
    logic         fits;

    always_comb begin
        shifted = {r_rem, r_quo[N-1]};
        diff    = {1'b0, shifted} - {2'b00, r_div};
        fits    = !diff[M+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_div  <= i_divisor;
            r_cnt  <= CW'(N);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_rem  <= fits ? diff[M-1:0] : shifted[M-1:0];
            r_quo  <= {r_quo[N-2:0], fits};
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == CW'(1));
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* sv/brs_front.sv */
`timescale 1ns / 1ps

module brs_front
    import brs_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  t_brs_in             i_item,
    output logic                o_full,
    input  logic [PERIOD_W-1:0] i_period,
    output logic                o_cmd_push,
    output t_brs_cmd            o_cmd,
    input  logic                i_cmd_full
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV1,
        S_DIV2,
        S_PUSH
    } t_state;

    t_state             r_state;
    logic [TIME_W-1:0]  r_elapsed;
    logic [WORD_W-1:0]  r_cur;
    logic               r_bit;
    logic               r_last;
    logic [CNT_W-1:0]   r_k1;
    logic [WORD_W-1:0]  r_cur1;
    logic               r_pulse;
    logic [IDX_W-1:0]   r_idx;
    logic [TIME_W-1:0]  r_t;
    t_brs_cmd           r_cmd;

    logic [RATE_W-1:0]   rate_sat;
    logic [RATE_W:0]     two_rate;
    logic [PERIOD_W-1:0] period_sat;
    logic                accept;
    logic                p_start;
    logic [TIME_W-1:0]   p_dividend;
    logic                p_done;
    logic [TIME_W-1:0]   p_quo;
    logic                d_done;
    logic [SEC_W-1:0]    d_quo;

    logic [TGT_W-1:0]  w;
    logic [CNT_W-1:0]  k1;
    logic [WORD_W-1:0] cur1;
    logic              hit;
    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] t_sat;

    logic [TGT_W-1:0]  tgt_run;
    logic [TIME_W:0]   end_up;
    logic [TGT_W-1:0]  tgt_ceil;
    logic [TGT_W-1:0]  cur1_next;
    logic [TGT_W-1:0]  tgt_flush;
    logic [TGT_W-1:0]  target;
    logic [CNT_W-1:0]  k2;

    function automatic logic [CNT_W-1:0] f_count(
        input logic [TGT_W-1:0]  tgt,
        input logic [WORD_W-1:0] cur,
        input logic [CNT_W-1:0]  cap
    );
        logic [WORD_W-1:0] diff;
        begin
            diff = tgt[WORD_W-1:0] - cur;
            if (tgt <= TGT_W'(cur)) begin
                return '0;
            end else if (tgt[TGT_W-1:WORD_W] != '0) begin
                return cap;
            end else if (diff < WORD_W'(cap)) begin
                return diff[CNT_W-1:0];
            end else begin
                return cap;
            end
        end
    endfunction

    always_comb begin
        if (i_item.cell_rate < RATE_MIN) begin
            rate_sat = RATE_MIN;
        end else if (i_item.cell_rate > RATE_MAX) begin
            rate_sat = RATE_MAX;
        end else begin
            rate_sat = i_item.cell_rate;
        end
        two_rate   = {rate_sat, 1'b0};
        period_sat = (i_period < PERIOD_MIN) ? PERIOD_MIN : i_period;
        accept     = (r_state == S_IDLE) && i_push;

        w    = TGT_W'(p_quo[TIME_W-1:IDX_W]);
        k1   = f_count(w, r_cur, MAX_RESULTS);
        cur1 = r_cur + WORD_W'(k1);
        hit  = (TGT_W'(cur1) == w);
        sum  = {1'b0, r_elapsed} + (TIME_W + 1)'(d_quo[DELTA_W-1:0]);
        t_sat = sum[TIME_W] ? '1 : sum[TIME_W-1:0];

        tgt_run   = TGT_W'(p_quo[TIME_W-1:IDX_W]);
        end_up    = {1'b0, p_quo} + (TIME_W + 1)'(15);
        tgt_ceil  = end_up[TGT_W+IDX_W-1:IDX_W];
        cur1_next = TGT_W'(r_cur1) + TGT_W'(1);
        tgt_flush = (tgt_ceil < cur1_next) ? cur1_next : tgt_ceil;
        target    = r_last ? tgt_flush : tgt_run;
        k2        = f_count(target, r_cur1, MAX_RESULTS - r_k1);

        p_start    = accept || ((r_state == S_DIV1) && p_done && d_done);
        p_dividend = (r_state == S_IDLE) ? r_elapsed : t_sat;
    end

    brs_div #(
        .N(TIME_W),
        .M(PERIOD_W)
    ) u_pdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (p_start),
        .i_dividend (p_dividend),
        .i_divisor  (period_sat),
        .o_done     (p_done),
        .o_quotient (p_quo)
    );

    brs_div #(
        .N(SEC_W),
        .M(RATE_W + 1)
    ) u_ddiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (ONE_SECOND_NS),
        .i_divisor  (two_rate),
        .o_done     (d_done),
        .o_quotient (d_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_elapsed <= '0;
            r_cur     <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_push) begin
                        r_bit   <= i_item.cell_bit;
                        r_last  <= i_item.last_cell;
                        r_state <= S_DIV1;
                    end
                end
                S_DIV1: begin
                    if (p_done && d_done) begin
                        r_k1    <= k1;
                        r_cur1  <= cur1;
                        r_pulse <= r_bit && hit;
                        r_idx   <= p_quo[IDX_W-1:0];
                        r_t     <= t_sat;
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (p_done) begin
                        r_cmd <= '{k1: r_k1, pulse: r_pulse, idx: r_idx,
                                   k2: k2, last: r_last};
                        if (r_last) begin
                            r_elapsed <= '0;
                            r_cur     <= '0;
                        end else begin
                            r_elapsed <= r_t;
                            r_cur     <= r_cur1 + WORD_W'(k2);
                        end
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (!i_cmd_full) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_full     = (r_state != S_IDLE);
    assign o_cmd_push = (r_state == S_PUSH) && !i_cmd_full;
    assign o_cmd      = r_cmd;

endmodule

/* sv/brs_cmdq.sv */
`timescale 1ns / 1ps

module brs_cmdq
    import brs_pkg::*;
#(
    parameter int DEPTH = CMDQ_DEPTH_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_brs_cmd i_data,
    output logic     o_full,
    input  logic     i_pop,
    output t_brs_cmd o_data,
    output logic     o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_brs_cmd      r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr;
    logic [PW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;

    logic do_push;
    logic do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

endmodule

/* sv/brs_back.sv */
`timescale 1ns / 1ps

module brs_back
    import brs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_brs_cmd i_cmd,
    input  logic     i_cmd_empty,
    output logic     o_cmd_pop,
    output logic     o_empty,
    input  logic     i_pop,
    output t_brs_out o_result
);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state               r_state;
    logic [SAMPLES_W-1:0] r_buf;
    logic [WORD_W-1:0]    r_cur;
    logic [CNT_W-1:0]     r_k1;
    logic [CNT_W-1:0]     r_k2;
    logic                 r_pulse;
    logic [IDX_W-1:0]     r_idx;
    logic                 r_last;
    logic                 r_out_valid;
    t_brs_out             r_out;

    logic emit_ok;
    logic emit;

    assign emit_ok   = !r_out_valid || i_pop;
    assign emit      = (r_state == S_RUN) && emit_ok
                       && ((r_k1 != '0) || (!r_pulse && (r_k2 != '0)));
    assign o_cmd_pop = (r_state == S_IDLE) && !i_cmd_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_buf       <= '0;
            r_cur       <= '0;
        end else begin
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_cmd_empty) begin
                        r_k1    <= i_cmd.k1;
                        r_k2    <= i_cmd.k2;
                        r_pulse <= i_cmd.pulse;
                        r_idx   <= i_cmd.idx;
                        r_last  <= i_cmd.last;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    priority if (r_k1 != '0) begin
                        if (emit_ok) begin
                            r_out <= '{sample_word: r_buf, word_number: r_cur,
                                       last_word: r_last && (r_k1 == CNT_W'(1))
                                                  && (r_k2 == '0)};
                            r_buf <= '0;
                            r_cur <= r_cur + 1'b1;
                            r_k1  <= r_k1 - 1'b1;
                        end
                    end else if (r_pulse) begin
                        r_buf   <= r_buf | (PULSE_MSB >> r_idx);
                        r_pulse <= 1'b0;
                    end else if (r_k2 != '0) begin
                        if (emit_ok) begin
                            r_out <= '{sample_word: r_buf, word_number: r_cur,
                                       last_word: r_last && (r_k2 == CNT_W'(1))};
                            r_buf <= '0;
                            r_cur <= r_cur + 1'b1;
                            r_k2  <= r_k2 - 1'b1;
                        end
                    end else begin
                        // restart the track after its final word
                        if (r_last) begin
                            r_buf <= '0;
                            r_cur <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_result = r_out;

endmodule
